FILE: sv/bslpd_pkg.sv
// ---------------------------------------------------------------------------
// bslpd_pkg: shared types and constants for the short/long press detector
// Field widths, register indexes and register reset values.
// ---------------------------------------------------------------------------
package bslpd_pkg;

   localparam int unsigned CNT_W      = 8;   // debounce counter width
   localparam int unsigned TICKS_W    = 8;   // threshold register width
   localparam int unsigned REQ_DATA_W = 8;   // pin_level, take_short, take_long, padding
   localparam int unsigned RSP_DATA_W = 8;   // short_press, long_press, padding
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 8'd4;
   localparam logic [TICKS_W-1:0] LONG_TICKS_RST     = 8'd70;

   // Pin is active low: pressed reads as 0.
   localparam logic PIN_PRESSED  = 1'b0;
   localparam logic PIN_RELEASED = 1'b1;

   // req_tdata bit positions
   localparam int unsigned REQ_PIN_BIT   = 0;
   localparam int unsigned REQ_TAKE_S    = 1;
   localparam int unsigned REQ_TAKE_L    = 2;
   // rsp_tdata bit positions
   localparam int unsigned RSP_SHORT_BIT = 0;
   localparam int unsigned RSP_LONG_BIT  = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE_TICKS = 1'b0,
      REG_LONG_TICKS     = 1'b1
   } csr_index_type;

endpackage

FILE: sv/button_short_long_press_detector.sv
// ---------------------------------------------------------------------------
// button_short_long_press_detector: debounced short and long press flags
// Two debouncers on one active-low pin sample stream, sticky press flags
// with read-to-clear strobes, one result beat per sample beat.
// ---------------------------------------------------------------------------
// Each req beat is one sample tick of the button pin (0 = pressed) plus two
// read-to-clear strobes. The block accepts one beat every clock cycle and
// returns exactly one rsp beat per req beat, valid from the cycle after
// acceptance, in order, out of the single result register; the debouncer
// state is updated in the same edge that takes the req beat. The result
// register frees itself as the rsp beat is taken, so req_tready stays high
// while the downstream side keeps up and drops only while a result waits
// on a low rsp_tready. The short debouncer accepts a level change after
// debounce_ticks differing samples; a press arms it and a release while
// armed sets the short flag. The long debouncer accepts a press after
// long_ticks samples (setting the long flag and disarming the short path)
// and a release after debounce_ticks samples. The flags are reported after
// the tick's update; a set strobe clears its flag after that report.
// A threshold of 0 behaves like 1. Write csr_* only while no beat is in
// flight.
// ---------------------------------------------------------------------------
module button_short_long_press_detector
   import bslpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample stream in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] pin_level, [1] take_short,
                                              // [2] take_long, [7:3] zero
   // flag stream out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] short_press, [1] long_press,
                                              // [7:2] zero
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TICKS_W-1:0]    csr_wdata
);

   // thresholds
   logic [TICKS_W-1:0] debounce_ticks_ff, debounce_ticks_in;
   logic [TICKS_W-1:0] long_ticks_ff,     long_ticks_in;

   // debouncer and flag state
   logic [CNT_W-1:0] short_cnt_ff, short_cnt_in;
   logic             short_level_ff, short_level_in;
   logic             armed_ff, armed_in;
   logic [CNT_W-1:0] long_cnt_ff, long_cnt_in;
   logic             long_level_ff, long_level_in;
   logic             short_flag_ff, short_flag_in;
   logic             long_flag_ff, long_flag_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_short_ff, rsp_short_in;
   logic             rsp_long_ff,  rsp_long_in;

   logic             req_beat;
   logic             pin;
   logic [CNT_W-1:0] short_cnt_inc, long_cnt_inc;
   logic [CNT_W-1:0] long_thr;
   logic             armed_mid;
   logic             short_upd, long_upd;

   // Result slot frees up as its beat leaves, so a new beat can land in the
   // same cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign pin        = req_tdata[REQ_PIN_BIT];

   // --- configuration ---
   always_comb begin
      debounce_ticks_in = debounce_ticks_ff;
      long_ticks_in     = long_ticks_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DEBOUNCE_TICKS: debounce_ticks_in = csr_wdata;
            REG_LONG_TICKS:     long_ticks_in     = csr_wdata;
            default:            ;
         endcase
      end
   end

   // --- debouncers: short path first, long path sees its armed update ---
   always_comb begin
      short_cnt_inc  = short_cnt_ff + 1'b1;
      long_cnt_inc   = long_cnt_ff + 1'b1;
      long_thr       = (pin == PIN_PRESSED) ? long_ticks_ff : debounce_ticks_ff;

      short_cnt_in   = short_cnt_ff;
      short_level_in = short_level_ff;
      long_cnt_in    = long_cnt_ff;
      long_level_in  = long_level_ff;
      armed_mid      = armed_ff;
      armed_in       = armed_ff;
      short_upd      = short_flag_ff;
      long_upd       = long_flag_ff;

      // short debouncer
      if (pin != short_level_ff) begin
         if (short_cnt_inc >= debounce_ticks_ff) begin
            short_level_in = pin;
            short_cnt_in   = '0;
            if (pin == PIN_PRESSED) begin
               armed_mid = 1'b1;
            end else if (armed_ff) begin
               short_upd = 1'b1;
            end
         end else begin
            short_cnt_in = short_cnt_inc;
         end
      end else begin
         short_cnt_in = '0;
      end

      // long debouncer; accepted long press disarms the short path
      armed_in = armed_mid;
      if (pin != long_level_ff) begin
         if (long_cnt_inc >= long_thr) begin
            long_level_in = pin;
            long_cnt_in   = '0;
            if (pin == PIN_PRESSED) begin
               long_upd = 1'b1;
               armed_in = 1'b0;
            end
         end else begin
            long_cnt_in = long_cnt_inc;
         end
      end else begin
         long_cnt_in = '0;
      end

      // report then clear on strobe
      rsp_short_in  = short_upd;
      rsp_long_in   = long_upd;
      short_flag_in = short_upd && !req_tdata[REQ_TAKE_S];
      long_flag_in  = long_upd  && !req_tdata[REQ_TAKE_L];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_TICKS_RST;
         long_ticks_ff     <= LONG_TICKS_RST;
         short_cnt_ff      <= '0;
         short_level_ff    <= PIN_RELEASED;
         armed_ff          <= 1'b0;
         long_cnt_ff       <= '0;
         long_level_ff     <= PIN_RELEASED;
         short_flag_ff     <= 1'b0;
         long_flag_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         debounce_ticks_ff <= debounce_ticks_in;
         long_ticks_ff     <= long_ticks_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (req_beat) begin
            short_cnt_ff   <= short_cnt_in;
            short_level_ff <= short_level_in;
            armed_ff       <= armed_in;
            long_cnt_ff    <= long_cnt_in;
            long_level_ff  <= long_level_in;
            short_flag_ff  <= short_flag_in;
            long_flag_ff   <= long_flag_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_short_ff <= rsp_short_in;
         rsp_long_ff  <= rsp_long_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   always_comb begin
      rsp_tdata                = '0;
      rsp_tdata[RSP_SHORT_BIT] = rsp_short_ff;
      rsp_tdata[RSP_LONG_BIT]  = rsp_long_ff;
   end

endmodule

FILE: sv/bslpd_checker.sv
// ---------------------------------------------------------------------------
// bslpd_checker: port-level checks for the press detector
// Watches the top-level ports only; bound to the top level below.
// ---------------------------------------------------------------------------
module bslpd_checker
   import bslpd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // every accepted sample yields a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no rsp beat after accepted req beat");

   // input side stalls only behind a blocked result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output backpressure");

   // a result appears only for an accepted sample
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("rsp beat without req beat");

endmodule

bind button_short_long_press_detector bslpd_checker u_bslpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/button_short_long_press_detector_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_short_long_press_detector_tb: self-checking bench for the press detector
// Streams pin sample beats through the block and checks every flag beat
// against an in-bench model of both debouncers and the sticky flags. Runs a
// short hand-built sequence, then random press episodes under several
// threshold settings, with random gaps on the sample side and random
// back-pressure on the flag side.
// ---------------------------------------------------------------------------
module button_short_long_press_detector_tb;
   import bslpd_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat at all
   localparam int unsigned NUM_PHASES  = 7;

   typedef struct packed {
      logic pin;
      logic take_s;
      logic take_l;
   } tick_type;

   typedef struct packed {
      logic short_press;
      logic long_press;
   } flags_type;

   // ------------------------------------------------------------------------
   // DUT ports, inputs all known from time zero
   // ------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [TICKS_W-1:0]    csr_wdata  = '0;

   button_short_long_press_detector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   tick_type    samples_to_send [$];   // sample beats not yet offered
   flags_type   flags_due [$];         // predicted flag beats, oldest first
   int unsigned mismatches  = 0;
   int unsigned phase_ticks = 0;
   int unsigned send_gap    = 0;
   int unsigned recv_stall  = 0;
   int unsigned idle_cycles = 0;
   bit          quiet       = 1'b0;    // no gaps or stalls while set

   // Per-phase thresholds and sample budgets. Zero and 255 show up on both
   // registers; the 255 phases overshoot their budget since one press takes
   // hundreds of ticks there.
   int unsigned db_set [NUM_PHASES] = '{4, 1, 0, 3, 2, 255, 1};
   int unsigned lt_set [NUM_PHASES] = '{70, 1, 0, 8, 16, 1, 255};
   int unsigned budget [NUM_PHASES] = '{220, 100, 70, 160, 160, 100, 150};

   // ------------------------------------------------------------------------
   // Debouncer model: its own copy of config and state
   // ------------------------------------------------------------------------
   logic [TICKS_W-1:0] debounce_cfg  = DEBOUNCE_TICKS_RST;
   logic [TICKS_W-1:0] long_cfg      = LONG_TICKS_RST;
   logic [CNT_W-1:0]   sd_count      = '0;   // short debouncer
   logic               sd_level      = PIN_RELEASED;
   logic               armed         = 1'b0;
   logic [CNT_W-1:0]   ld_count      = '0;   // long debouncer
   logic               ld_level      = PIN_RELEASED;
   logic               short_pending = 1'b0;
   logic               long_pending  = 1'b0;

   // One sample tick: short path first (may arm), then long path (may disarm).
   // Flags are reported after the update, strobes clear them afterwards.
   task automatic track_button_tick(input logic pin, input logic take_s,
                                    input logic take_l);
      flags_type got;
      if (pin != sd_level) begin
         sd_count = sd_count + 1'b1;
         // threshold 0 falls out as "accept on first differing sample"
         if (sd_count >= debounce_cfg) begin
            sd_level = pin;
            if (pin == PIN_PRESSED) begin
               armed = 1'b1;
            end else if (armed) begin
               // release does not disarm; only a long press does
               short_pending = 1'b1;
            end
            sd_count = '0;
         end
      end else begin
         sd_count = '0;
      end

      if (pin != ld_level) begin
         ld_count = ld_count + 1'b1;
         if ((pin == PIN_PRESSED && ld_count >= long_cfg) ||
             (pin == PIN_RELEASED && ld_count >= debounce_cfg)) begin
            ld_level = pin;
            if (pin == PIN_PRESSED) begin
               long_pending = 1'b1;
               armed        = 1'b0;
            end
            ld_count = '0;
         end
      end else begin
         ld_count = '0;
      end

      got.short_press = short_pending;
      got.long_press  = long_pending;
      flags_due.push_back(got);

      if (take_s) begin
         short_pending = 1'b0;
      end
      if (take_l) begin
         long_pending = 1'b0;
      end
   endtask

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_tick(input logic pin, input logic take_s, input logic take_l);
      tick_type t;
      t.pin    = pin;
      t.take_s = take_s;
      t.take_l = take_l;
      samples_to_send.push_back(t);
      phase_ticks++;
   endtask

   // pin sample with random read-to-clear strobes
   task automatic push_pin(input logic pin);
      push_tick(pin, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
   endtask

   task automatic push_bounce();
      int unsigned n;
      n = $urandom_range(0, 3);
      repeat (n) push_pin(1'($urandom_range(0, 1)));
   endtask

   // One press episode: bounce, hold, bounce, release. Hold lengths cluster
   // around both thresholds so presses land just short of and just past
   // acceptance. Some episodes are plain noise instead.
   task automatic add_episode(input int unsigned d, input int unsigned l);
      int unsigned hold;
      int unsigned rel;
      int unsigned n;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) push_pin(1'($urandom_range(0, 1)));
      end else begin
         push_bounce();
         case ($urandom_range(0, 2))
            0: begin
               hold = $urandom_range(1, d + 2);
            end
            1: begin
               hold = $urandom_range(l > 2 ? l - 2 : 1, l + 2);
            end
            default: begin
               hold = $urandom_range(1, (d > l ? d : l) + 3);
            end
         endcase
         repeat (hold) push_pin(PIN_PRESSED);
         push_bounce();
         if ($urandom_range(0, 3) == 0) begin
            rel = $urandom_range(1, d + 3);     // may be cut short
         end else begin
            rel = $urandom_range(d, d + 4);
         end
         repeat (rel) push_pin(PIN_RELEASED);
      end
   endtask

   // Register write; only called with nothing in flight.
   task automatic write_reg(input csr_index_type idx, input logic [TICKS_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_DEBOUNCE_TICKS) begin
         debounce_cfg = val;
      end else begin
         long_cfg = val;
      end
   endtask

   // Wait until every queued sample went in and every flag beat came out.
   // Checked between edges so the driver and monitor updates have landed.
   task automatic wait_idle();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_tvalid || rsp_tvalid ||
             flags_due.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Sample driver: offers queued beats, predicts each one as it is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [REQ_DATA_W-1:0] word;
      tick_type              nxt_tick;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_button_tick(req_tdata[REQ_PIN_BIT], req_tdata[REQ_TAKE_S],
                              req_tdata[REQ_TAKE_L]);
         end
         // slot is free: either nothing offered or the offer was just taken
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0 || samples_to_send.size() == 0) begin
               if (send_gap != 0) begin
                  send_gap--;
               end
               req_tvalid <= 1'b0;
            end else begin
               nxt_tick              = samples_to_send.pop_front();
               word                  = '0;
               word[REQ_PIN_BIT]     = nxt_tick.pin;
               word[REQ_TAKE_S]      = nxt_tick.take_s;
               word[REQ_TAKE_L]      = nxt_tick.take_l;
               req_tdata            <= word;
               req_tvalid           <= 1'b1;
               send_gap              = pick_gap();
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Flag monitor: random back-pressure, checks each beat against the model
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      flags_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (flags_due.size() == 0) begin
               $error("flag beat with nothing expected: short_press %0b long_press %0b",
                      rsp_tdata[RSP_SHORT_BIT], rsp_tdata[RSP_LONG_BIT]);
               mismatches++;
            end else begin
               want = flags_due.pop_front();
               if (rsp_tdata[RSP_SHORT_BIT] !== want.short_press) begin
                  $error("short_press: expected %0b, got %0b",
                         want.short_press, rsp_tdata[RSP_SHORT_BIT]);
                  mismatches++;
               end
               if (rsp_tdata[RSP_LONG_BIT] !== want.long_press) begin
                  $error("long_press: expected %0b, got %0b",
                         want.long_press, rsp_tdata[RSP_LONG_BIT]);
                  mismatches++;
               end
            end
         end
         if (recv_stall != 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall  = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any beat on either side means a hang
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      // Hand-built run at debounce 2 / long 4, one column per tick:
      //   lone glitch, short press and release (short flag), strobe clear,
      //   long press (long flag, short path disarmed so its release is
      //   silent), strobes on set and on clear flags, and a short release
      //   whose flag is raised and strobed in the same tick.
      logic [0:22] dir_pin = 23'b10100111100000111100111;
      logic [0:22] dir_ts  = 23'b00000001000000000100010;
      logic [0:22] dir_tl  = 23'b00000000000000001100000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_DEBOUNCE_TICKS, 8'd2);
      write_reg(REG_LONG_TICKS, 8'd4);
      for (int i = 0; i < 23; i++) begin
         push_tick(dir_pin[i], dir_ts[i], dir_tl[i]);
      end
      wait_idle();

      // Random episodes, one threshold setting per phase; every third phase
      // runs without gaps or back-pressure.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(REG_DEBOUNCE_TICKS, TICKS_W'(db_set[p]));
         write_reg(REG_LONG_TICKS, TICKS_W'(lt_set[p]));
         quiet       = (p % 3 == 2);
         phase_ticks = 0;
         while (phase_ticks < budget[p]) begin
            add_episode(db_set[p] == 0 ? 1 : db_set[p], lt_set[p] == 0 ? 1 : lt_set[p]);
         end
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
